// ===== sv/scm_pkg.sv =====
package scm_pkg;

  localparam int MAX_COLS_DEF  = 8;
  localparam int ACC_WIDTH_DEF = 48;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 4;
  localparam int IDX_W    = 3;
  localparam int ST_W     = 2;
  localparam int CORR_W   = 16;
  localparam int Q_W      = 15;
  localparam int FRAC_W   = 14;

  localparam logic [0:0] CFG_TOTAL_COLS = 1'b0;
  localparam logic [0:0] CFG_COLS_REQ   = 1'b1;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FEW  = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

  // Packed lower-triangle address of entry (a, b).
  function automatic logic [5:0] tri_addr(input logic [2:0] a, input logic [2:0] b);
    logic [5:0] r;
    logic [5:0] c;
    begin
      r = (a > b) ? {3'b0, a} : {3'b0, b};
      c = (a > b) ? {3'b0, b} : {3'b0, a};
      return 6'((r * (r + 6'd1)) >> 1) + c;
    end
  endfunction

endpackage

// ===== sv/score_correlation_matrix_unit.sv =====
// Cosine-similarity Gram matrix of a streamed score matrix. Samples arrive row-major;
// total_cols sets the row length. A sample at column position p is accepted, then
// its p+1 products go one at a time through the single multiplier and a
// read-modify-write of the Gram memory, which has one read and one write port.
// On the sample marked last the block checks the d diagonal entries and then
// emits the d*d correlations in Q2.14, one at a time and held by any output
// stall: each takes three Gram reads, a start step, shift-add multiplies forming
// di*dj and g*g, and a 14-bit root search (skipped when the magnitude clamps to
// 1.0). Fewer than two columns gives one result with status 1, a zero-norm column
// one with status 2. The Gram store is cleared through per-entry valid bits, so
// no clearing pass exists.
module score_correlation_matrix_unit import scm_pkg::*; #(
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [CORR_W-1:0]   out_corr_value,
  output logic [IDX_W-1:0]           out_row_index,
  output logic [IDX_W-1:0]           out_col_index,
  output logic [ST_W-1:0]            out_status,
  output logic                       out_last_result
);

  localparam int GD = MAX_COLS * (MAX_COLS + 1) / 2;
  localparam int GW = $clog2(GD);
  localparam int CW = $clog2(MAX_COLS);
  localparam logic [CFG_W-1:0] MAXC = CFG_W'(MAX_COLS);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_ACC_RD   = 11'b00000000010,
    S_ACC_WR   = 11'b00000000100,
    S_FIN      = 11'b00000001000,
    S_DIAG_RD  = 11'b00000010000,
    S_DIAG_CHK = 11'b00000100000,
    S_RD_G     = 11'b00001000000,
    S_RD_DI    = 11'b00010000000,
    S_RD_DJ    = 11'b00100000000,
    S_START    = 11'b01000000000,
    S_CORR     = 11'b10000000000
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0]           total_cols_r, cols_req_r, total, d_r, dsel;
  logic [CW-1:0]              pos_r, p_r, j_r, i_r, p_in;
  logic signed [SAMPLE_W-1:0] rb_r [MAX_COLS];
  logic signed [SAMPLE_W-1:0] v_r;
  logic                       last_r;
  logic signed [31:0]         prod_r;
  logic [GD-1:0]              vld_r;
  logic                       vld_rd_r;
  logic [GW-1:0]              raddr;
  logic [ACC_WIDTH-1:0]       rdata;
  logic signed [ACC_WIDTH-1:0] gval, g_r, di_r, acc_new;
  logic signed [ACC_WIDTH:0]  sum;
  logic                       we;
  logic [ACC_WIDTH-1:0]       g_mag;
  logic                       c_start, c_done;
  logic [Q_W-1:0]             c_q;
  logic                       slot_free, j_end, i_end;
  logic                       out_load;

  // effective column count: zero acts as one, clamp at MAX_COLS
  always_comb begin
    total = total_cols_r;
    if (total == '0) total = CFG_W'(1);
    if (total > MAXC) total = MAXC;
    dsel = cols_req_r;
    if (dsel == '0 || dsel > total) dsel = total;
  end

  assign p_in      = (CFG_W'(pos_r) >= total) ? '0 : pos_r;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign gval      = vld_rd_r ? signed'(rdata) : '0;
  assign j_end     = (CFG_W'(j_r) == d_r - CFG_W'(1));
  assign i_end     = (CFG_W'(i_r) == d_r - CFG_W'(1));
  assign g_mag     = g_r[ACC_WIDTH-1] ? ACC_WIDTH'(-g_r) : ACC_WIDTH'(g_r);
  assign c_start   = (state_r == S_START);

  // a new request enters the output register this cycle
  assign out_load  = slot_free &&
                     ((state_r == S_FIN && dsel < CFG_W'(2)) ||
                      (state_r == S_DIAG_CHK && gval == '0) ||
                      (state_r == S_CORR && c_done));

  always_comb begin
    case (state_r)
      S_ACC_RD:  raddr = GW'(tri_addr(3'(p_r), 3'(j_r)));
      // keep reading the diagonal while a zero-norm report waits
      S_DIAG_RD, S_DIAG_CHK: raddr = GW'(tri_addr(3'(i_r), 3'(i_r)));
      S_RD_G:    raddr = GW'(tri_addr(3'(i_r), 3'(j_r)));
      S_RD_DI:   raddr = GW'(tri_addr(3'(i_r), 3'(i_r)));
      S_RD_DJ:   raddr = GW'(tri_addr(3'(j_r), 3'(j_r)));
      default:   raddr = '0;
    endcase
  end

  // saturating accumulate of the registered product
  always_comb begin
    sum = {gval[ACC_WIDTH-1], gval} + (ACC_WIDTH+1)'(prod_r);
    if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
      acc_new = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                               : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      acc_new = sum[ACC_WIDTH-1:0];
    end
  end

  assign we = (state_r == S_ACC_WR);

  scm_ram #(
    .WIDTH(ACC_WIDTH),
    .DEPTH(GD)
  ) u_gram (
    .clk  (clk),
    .we   (we),
    .waddr(GW'(tri_addr(3'(p_r), 3'(j_r)))),
    .wdata(acc_new),
    .raddr(raddr),
    .rdata(rdata)
  );

  scm_corr #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_corr (
    .clk  (clk),
    .rst_n(rst_n),
    .start(c_start),
    .g_mag(g_mag),
    .di   (di_r),
    .dj   (gval),
    .done (c_done),
    .q    (c_q)
  );

  always_ff @(posedge clk) begin
    vld_rd_r <= vld_r[raddr];
    if (state_r == S_IDLE && in_valid) begin
      v_r        <= in_sample;
      last_r     <= in_last_sample;
      p_r        <= p_in;
      rb_r[p_in] <= in_sample;
    end
    if (state_r == S_ACC_RD) prod_r <= v_r * rb_r[j_r];
    if (state_r == S_RD_DI)  g_r <= gval;
    if (state_r == S_RD_DJ)  di_r <= gval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      total_cols_r    <= MAXC;
      cols_req_r      <= '0;
      pos_r           <= '0;
      j_r             <= '0;
      i_r             <= '0;
      d_r             <= '0;
      vld_r           <= '0;
      out_valid       <= 1'b0;
      out_corr_value  <= '0;
      out_row_index   <= '0;
      out_col_index   <= '0;
      out_status      <= ST_OK;
      out_last_result <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL_COLS: total_cols_r <= cfg_data;
          CFG_COLS_REQ:   cols_req_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            j_r     <= '0;
            state_r <= S_ACC_RD;
          end
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          vld_r[GW'(tri_addr(3'(p_r), 3'(j_r)))] <= 1'b1;
          if (j_r == p_r) begin
            pos_r   <= (CFG_W'(p_r) + CFG_W'(1) >= total) ? '0 : CW'(p_r + CW'(1));
            state_r <= last_r ? S_FIN : S_IDLE;
          end else begin
            j_r     <= j_r + CW'(1);
            state_r <= S_ACC_RD;
          end
        end
        S_FIN: begin
          d_r <= dsel;
          i_r <= '0;
          j_r <= '0;
          if (dsel < CFG_W'(2)) begin
            if (slot_free) begin
              out_valid       <= 1'b1;
              out_corr_value  <= '0;
              out_row_index   <= '0;
              out_col_index   <= '0;
              out_status      <= ST_FEW;
              out_last_result <= 1'b1;
              vld_r           <= '0;
              pos_r           <= '0;
              state_r         <= S_IDLE;
            end
          end else begin
            state_r <= S_DIAG_RD;
          end
        end
        S_DIAG_RD: state_r <= S_DIAG_CHK;
        S_DIAG_CHK: begin
          if (gval == '0) begin
            // zero norm: hold until the output slot frees, then report
            if (slot_free) begin
              out_valid       <= 1'b1;
              out_corr_value  <= '0;
              out_row_index   <= '0;
              out_col_index   <= '0;
              out_status      <= ST_ZERO;
              out_last_result <= 1'b1;
              vld_r           <= '0;
              pos_r           <= '0;
              state_r         <= S_IDLE;
            end
          end else if (i_end) begin
            i_r     <= '0;
            state_r <= S_RD_G;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_DIAG_RD;
          end
        end
        S_RD_G:  state_r <= S_RD_DI;
        S_RD_DI: state_r <= S_RD_DJ;
        S_RD_DJ: state_r <= S_START;
        S_START: state_r <= S_CORR;
        S_CORR: begin
          if (c_done && slot_free) begin
            out_valid       <= 1'b1;
            out_corr_value  <= g_r[ACC_WIDTH-1] ? -CORR_W'(c_q) : CORR_W'(c_q);
            out_row_index   <= IDX_W'(i_r);
            out_col_index   <= IDX_W'(j_r);
            out_status      <= ST_OK;
            out_last_result <= i_end && j_end;
            if (j_end) begin
              j_r <= '0;
              i_r <= i_r + CW'(1);
            end else begin
              j_r <= j_r + CW'(1);
            end
            if (i_end && j_end) begin
              vld_r   <= '0;
              pos_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_RD_G;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/scm_ram.sv =====
module scm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/scm_corr.sv =====
module scm_corr import scm_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ACC_WIDTH-1:0] g_mag,
  input  logic [ACC_WIDTH-1:0] di,
  input  logic [ACC_WIDTH-1:0] dj,
  output logic                 done,
  output logic [Q_W-1:0]       q
);

  localparam int PW = 2 * ACC_WIDTH;
  localparam int W  = PW + 30;
  localparam int MCW = $clog2(ACC_WIDTH + 1);

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_MUL  = 6'b000010,
    C_CAP  = 6'b000100,
    C_A    = 6'b001000,
    C_B    = 6'b010000,
    C_DONE = 6'b100000
  } cstate_t;

  cstate_t state_r, state_nxt;

  logic [PW-1:0]        pa_r, ga_r, p_r, gg_r;
  logic [ACC_WIDTH-1:0] pb_r, gb_r;
  logic [MCW-1:0]       mcnt_r;
  logic [W-1:0]         r_r, s_r, u_r, pk_r, tmp_r;
  logic [3:0]           kcnt_r;
  logic [FRAC_W-1:0]    qb_r;
  logic                 cap_r;
  logic [W-1:0]         cand;
  logic                 fit;

  assign cand = tmp_r + pk_r;
  assign fit  = (cand <= r_r);
  assign done = (state_r == C_DONE);
  assign q    = cap_r ? Q_W'(1 << FRAC_W) : {1'b0, qb_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: if (start) state_nxt = C_MUL;
      C_MUL:  if (mcnt_r == MCW'(1)) state_nxt = C_CAP;
      C_CAP:  state_nxt = (p_r <= gg_r) ? C_DONE : C_A;
      C_A:    state_nxt = C_B;
      C_B:    state_nxt = (kcnt_r == 4'd1) ? C_DONE : C_A;
      C_DONE: if (start) state_nxt = C_MUL;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pa_r   <= PW'(di);
      pb_r   <= dj;
      ga_r   <= PW'(g_mag);
      gb_r   <= g_mag;
      p_r    <= '0;
      gg_r   <= '0;
      mcnt_r <= MCW'(ACC_WIDTH);
      cap_r  <= 1'b0;
    end else begin
      case (state_r)
        C_MUL: begin
          // shift-add multiply, one multiplier bit per cycle
          if (pb_r[0]) p_r <= p_r + pa_r;
          if (gb_r[0]) gg_r <= gg_r + ga_r;
          pa_r   <= pa_r << 1;
          ga_r   <= ga_r << 1;
          pb_r   <= pb_r >> 1;
          gb_r   <= gb_r >> 1;
          mcnt_r <= mcnt_r - MCW'(1);
        end
        C_CAP: begin
          cap_r  <= (p_r <= gg_r);
          r_r    <= W'(gg_r) << 28;
          pk_r   <= W'(p_r) << 26;
          s_r    <= '0;
          u_r    <= '0;
          qb_r   <= '0;
          kcnt_r <= 4'(FRAC_W);
        end
        C_A: tmp_r <= s_r + u_r;
        C_B: begin
          // u holds q*P shifted for the current bit; pk holds P << 2k
          if (fit) s_r <= cand;
          u_r    <= (u_r >> 1) + (fit ? pk_r : '0);
          pk_r   <= pk_r >> 2;
          qb_r   <= {qb_r[FRAC_W-2:0], fit};
          kcnt_r <= kcnt_r - 4'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/scm_checker.sv =====
module scm_checker import scm_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [CORR_W-1:0]   out_corr_value,
  input logic [IDX_W-1:0]           out_row_index,
  input logic [IDX_W-1:0]           out_col_index,
  input logic [ST_W-1:0]            out_status,
  input logic                       out_last_result
);

  // a stalled request stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last_result)
    else $error("error status not final");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_corr_value == '0 && out_row_index == '0 && out_col_index == '0)
    else $error("error result carries data");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_corr_value <= 16'sd16384 && out_corr_value >= -16'sd16384)
    else $error("correlation out of range");

  a_diag_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && out_row_index == out_col_index |->
      out_corr_value == 16'sd16384)
    else $error("diagonal not one");

endmodule

bind score_correlation_matrix_unit scm_checker u_scm_checker (.*);

// ===== dv/tb_score_correlation_matrix_unit.sv =====
`timescale 1ns / 1ps

module tb_score_correlation_matrix_unit;
  import scm_pkg::*;

  typedef struct {
    logic signed [CORR_W-1:0] corr;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic [ST_W-1:0]          status;
    logic                     last;
  } corr_entry_t;

  // one directed request; typed rows carry a status-only expectation
  typedef struct {
    int                   tc;
    int                   rq;
    logic signed [15:0]   smp;
    bit                   lst;
    bit                   typed;
    logic [ST_W-1:0]      status;
  } stim_row_t;

  localparam longint ACC_MAX = (64'sd1 <<< (ACC_WIDTH_DEF - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam int     CYCLE_LIMIT = 20000000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [0:0]               cfg_index = CFG_TOTAL_COLS;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                     in_last_sample = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [CORR_W-1:0] out_corr_value;
  logic [IDX_W-1:0]         out_row_index;
  logic [IDX_W-1:0]         out_col_index;
  logic [ST_W-1:0]          out_status;
  logic                     out_last_result;

  score_correlation_matrix_unit u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  int     cur_tc = 8;
  int     cur_rq = 0;
  longint row_buf[MAX_COLS_DEF];
  longint gram[36];
  int     col_pos = 0;

  corr_entry_t pending_corr[$];
  int     fails = 0;
  int     src_idle_pct = 0;
  int     sink_stall_pct = 0;
  int     hold_cycles = 0;
  int     cycle_cnt = 0;
  int     items_sent = 0;

  function automatic int tri_idx(int a, int b);
    int r;
    int c;
    r = (a > b) ? a : b;
    c = (a > b) ? b : a;
    return r * (r + 1) / 2 + c;
  endfunction

  // largest q with q*q*di*dj <= 2^28 * g*g, sign of g, clamped to 1.0
  function automatic logic signed [CORR_W-1:0] corr_q14(longint g, longint di, longint dj);
    bit [127:0] lhs;
    bit [127:0] rhs;
    bit [127:0] ag;
    int lo;
    int hi;
    int mid;
    ag = (g < 0) ? 128'(-g) : 128'(g);
    lhs = (ag * ag) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      rhs = 128'(di) * 128'(dj) * 128'(mid * mid);
      if (rhs <= lhs) lo = mid;
      else hi = mid - 1;
    end
    return (g < 0) ? -CORR_W'(lo) : CORR_W'(lo);
  endfunction

  task automatic absorb_sample(input logic signed [15:0] smp, input bit lst,
                               output corr_entry_t res[$]);
    int t;
    int d;
    longint v;
    longint acc;
    bit zero_norm;
    corr_entry_t e;
    res = {};
    t = (cur_tc == 0) ? 1 : (cur_tc > MAX_COLS_DEF) ? MAX_COLS_DEF : cur_tc;
    v = smp;
    if (col_pos >= t) col_pos = 0;
    row_buf[col_pos] = v;
    for (int j = 0; j <= col_pos; j++) begin
      acc = gram[tri_idx(col_pos, j)] + v * row_buf[j];
      if (acc > ACC_MAX) acc = ACC_MAX;
      if (acc < ACC_MIN) acc = ACC_MIN;
      gram[tri_idx(col_pos, j)] = acc;
    end
    col_pos = (col_pos + 1 >= t) ? 0 : col_pos + 1;
    if (!lst) return;
    d = cur_rq;
    if (d == 0 || d > t) d = t;
    e = '{corr: '0, row: '0, col: '0, status: ST_OK, last: 1'b1};
    if (d < 2) begin
      e.status = ST_FEW;
      res.push_back(e);
    end else begin
      zero_norm = 0;
      for (int i = 0; i < d; i++) if (gram[tri_idx(i, i)] == 0) zero_norm = 1;
      if (zero_norm) begin
        e.status = ST_ZERO;
        res.push_back(e);
      end else begin
        for (int i = 0; i < d; i++)
          for (int j = 0; j < d; j++) begin
            e.corr = corr_q14(gram[tri_idx(i, j)], gram[tri_idx(i, i)],
                              gram[tri_idx(j, j)]);
            e.row = i;
            e.col = j;
            e.status = ST_OK;
            e.last = (i == d - 1 && j == d - 1);
            res.push_back(e);
          end
      end
    end
    foreach (gram[k]) gram[k] = 0;
    col_pos = 0;
  endtask

  // if either register changes, hold off until the block is quiet, then rewrite both
  task automatic write_regs(input int tc, input int rq);
    if (tc == cur_tc && rq == cur_rq) return;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_corr.size() == 0);
    repeat (100) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TOTAL_COLS;
    cfg_data <= CFG_W'(tc);
    @(negedge clk);
    cfg_index <= CFG_COLS_REQ;
    cfg_data <= CFG_W'(rq);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_tc = tc;
    cur_rq = rq;
  endtask

  task automatic send_sample(input logic signed [15:0] smp, input bit lst,
                             input bit typed, input logic [ST_W-1:0] status);
    corr_entry_t res[$];
    corr_entry_t e;
    if ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= smp;
    in_last_sample <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
    absorb_sample(smp, lst, res);
    if (typed) begin
      e = '{corr: '0, row: '0, col: '0, status: status, last: 1'b1};
      pending_corr.push_back(e);
    end else begin
      foreach (res[k]) pending_corr.push_back(res[k]);
    end
  endtask

  function automatic logic signed [15:0] pick_sample(int mode, int col);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(20)) - 10);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return (col == 0) ? 16'sd0 : 16'($urandom);
    endcase
  endfunction

  task automatic send_matrix(input int tc, input int rq, input int rows);
    int t;
    int n;
    int stop;
    int mode;
    write_regs(tc, rq);
    t = (tc == 0) ? 1 : (tc > MAX_COLS_DEF) ? MAX_COLS_DEF : tc;
    n = rows * t;
    // mostly whole rows; sometimes stop early at a random sample
    stop = ($urandom_range(3) == 0) ? $urandom_range(1, n) : n;
    mode = $urandom_range(3);
    for (int k = 0; k < stop; k++) begin
      // change the row length mid-matrix now and then
      if (k == stop / 2 && k > 0 && $urandom_range(9) == 0)
        write_regs($urandom_range(1, 8), cur_rq);
      send_sample(pick_sample(mode, k % t), k == stop - 1, 1'b0, ST_OK);
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    corr_entry_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_corr.size() == 0) begin
        $display("%0t: unexpected result corr=%0d row=%0d col=%0d status=%0d",
                 $time, out_corr_value, out_row_index, out_col_index, out_status);
        fails++;
      end else begin
        e = pending_corr.pop_front();
        if (out_corr_value !== e.corr || out_row_index !== e.row ||
            out_col_index !== e.col || out_status !== e.status ||
            out_last_result !== e.last) begin
          $display("%0t: mismatch expected corr=%0d row=%0d col=%0d st=%0d last=%0d",
                   $time, e.corr, e.row, e.col, e.status, e.last);
          $display("%0t:          actual   corr=%0d row=%0d col=%0d st=%0d last=%0d",
                   $time, out_corr_value, out_row_index, out_col_index,
                   out_status, out_last_result);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("score_correlation_matrix_unit regression: fail");
      $finish;
    end
  end

  stim_row_t dir_rows[] = '{
    '{1, 0, 16'sh7fff, 1, 1, ST_FEW},
    '{2, 0, 16'sh8000, 0, 0, ST_OK},
    '{2, 0, 16'sh7fff, 0, 0, ST_OK},
    '{2, 0, 16'sh8000, 0, 0, ST_OK},
    '{2, 0, 16'sh7fff, 1, 0, ST_OK},
    '{2, 0, 16'sd0,    0, 0, ST_OK},
    '{2, 0, 16'sd1,    0, 0, ST_OK},
    '{2, 0, 16'sd0,    1, 1, ST_ZERO},
    '{8, 1, 16'sd5,    1, 1, ST_FEW},
    '{3, 9, 16'sd1,    0, 0, ST_OK},
    '{3, 9, -16'sd2,   0, 0, ST_OK},
    '{3, 9, 16'sd3,    0, 0, ST_OK},
    '{3, 9, 16'sd4,    1, 0, ST_OK},
    '{15, 8, 16'sh7fff, 0, 0, ST_OK},
    '{15, 8, 16'sh8000, 0, 0, ST_OK},
    '{15, 8, 16'sd1,    0, 0, ST_OK},
    '{15, 8, -16'sd1,   0, 0, ST_OK},
    '{15, 8, 16'sh5555, 0, 0, ST_OK},
    '{15, 8, 16'shaaaa, 0, 0, ST_OK},
    '{15, 8, 16'sd100,  0, 0, ST_OK},
    '{15, 8, -16'sd7,   1, 0, ST_OK},
    '{0, 0, 16'sd0,    1, 1, ST_FEW}
  };

  initial begin
    int phase;
    foreach (gram[k]) gram[k] = 0;
    foreach (row_buf[k]) row_buf[k] = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      write_regs(dir_rows[k].tc, dir_rows[k].rq);
      send_sample(dir_rows[k].smp, dir_rows[k].lst, dir_rows[k].typed,
                  dir_rows[k].status);
    end

    // 8-column matrix, then hold off the receiver; the 3-column matrix waits for it to drain
    send_matrix(8, 0, 1);
    hold_cycles = 600;
    send_matrix(3, 0, 4);

    phase = 0;
    while (items_sent < 420) begin
      if (items_sent >= 100 + 80 * phase && phase < 4) begin
        case (phase)
          0: begin src_idle_pct = 56; sink_stall_pct = 0; end
          1: begin src_idle_pct = 0; sink_stall_pct = 56; end
          2: begin src_idle_pct = 25; sink_stall_pct = 25; end
          default: begin src_idle_pct = 0; sink_stall_pct = 0; end
        endcase
        phase++;
      end
      case ($urandom_range(9))
        0: send_matrix($urandom_range(5, 8), $urandom_range(2) ? 0 : $urandom_range(15),
                       $urandom_range(1, 2));
        1: send_matrix($urandom_range(15), $urandom_range(15), $urandom_range(1, 3));
        default: send_matrix($urandom_range(2, 4), $urandom_range(3) ? 0 : $urandom_range(15),
                             $urandom_range(1, 4));
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_corr.size() == 0);
    repeat (200) @(negedge clk);
    if (fails == 0) $display("score_correlation_matrix_unit regression: pass");
    else $display("score_correlation_matrix_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/scm_pkg.sv
sv/scm_ram.sv
sv/scm_corr.sv
sv/score_correlation_matrix_unit.sv
sv/scm_checker.sv
dv/tb_score_correlation_matrix_unit.sv
